// ===== rtl/core/fls_pkg.sv =====
package fls_pkg;

   localparam int unsigned FRAME_WIDTH   = 20;
   localparam int unsigned SAMPLES_WIDTH = 8;
   localparam int unsigned PERCENT_WIDTH = 7;
   localparam int unsigned SLEEP_WIDTH   = 10;
   localparam int unsigned DEFAULT_WIDTH = 16;
   localparam int unsigned STABLE_WIDTH  = 16;
   localparam int unsigned CSR_WIDTH     = 20;
   localparam int unsigned INDEX_WIDTH   = 3;
   localparam int unsigned PROD_WIDTH    = 15;

   localparam logic [INDEX_WIDTH-1:0] CSR_SAMPLES_PER_WINDOW = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] CSR_FRAME_PERIOD_US    = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] CSR_MAX_LAG_PERCENT    = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] CSR_MAX_SLEEP_TIME     = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] CSR_DEFAULT_DELAY      = 3'd4;

   localparam logic [SAMPLES_WIDTH-1:0] RST_SAMPLES_PER_WINDOW = 8'd60;
   localparam logic [FRAME_WIDTH-1:0]   RST_FRAME_PERIOD_US    = 20'd16667;
   localparam logic [PERCENT_WIDTH-1:0] RST_MAX_LAG_PERCENT    = 7'd5;
   localparam logic [SLEEP_WIDTH-1:0]   RST_MAX_SLEEP_TIME     = 10'd16;
   localparam logic [DEFAULT_WIDTH-1:0] RST_DEFAULT_DELAY      = 16'd10;

   localparam logic [SAMPLES_WIDTH-1:0] LAG_COUNT_MAX  = 8'hFF;
   localparam logic [STABLE_WIDTH-1:0]  STABLE_MAX     = 16'hFFFF;
   localparam logic [STABLE_WIDTH-1:0]  RECENT_LIMIT   = 16'd3;
   localparam logic [PROD_WIDTH-1:0]    PERCENT_SCALE  = 15'd100;

   typedef enum logic [1:0] {
      CHANGE_NONE = 2'd0,
      CHANGE_UP   = 2'd1,
      CHANGE_DOWN = 2'd2
   } change_type;

   typedef struct packed {
      logic                     done;
      logic [SAMPLES_WIDTH-1:0] lags;
      logic [SAMPLES_WIDTH-1:0] size;
   } win_type;

endpackage

// ===== rtl/core/fls_window.sv =====
module fls_window (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic [fls_pkg::FRAME_WIDTH-1:0]      frame_time_us,
   input  logic [fls_pkg::SAMPLES_WIDTH-1:0]    samples_per_window,
   input  logic [fls_pkg::FRAME_WIDTH-1:0]      frame_period_us,
   output fls_pkg::win_type                     win
);

   logic [fls_pkg::SAMPLES_WIDTH-1:0] position_ff, position_in;
   logic [fls_pkg::SAMPLES_WIDTH-1:0] lag_count_ff, lag_count_in;
   logic [fls_pkg::SAMPLES_WIDTH-1:0] lag_count_next;
   logic [fls_pkg::SAMPLES_WIDTH:0]   position_next;
   logic [fls_pkg::SAMPLES_WIDTH-1:0] size;
   logic [fls_pkg::FRAME_WIDTH+1:0]   frame_twice;
   logic [fls_pkg::FRAME_WIDTH+1:0]   period_thrice;
   logic                              lag;
   logic                              done;

   // lag when twice the frame time exceeds three periods
   assign frame_twice   = {1'b0, frame_time_us, 1'b0};
   assign period_thrice = {2'b00, frame_period_us} + {1'b0, frame_period_us, 1'b0};
   assign lag           = frame_twice > period_thrice;

   assign size           = (samples_per_window == '0) ? 8'd1 : samples_per_window;
   assign lag_count_next = (lag && lag_count_ff != fls_pkg::LAG_COUNT_MAX) ?
                           lag_count_ff + 8'd1 : lag_count_ff;
   assign position_next  = {1'b0, position_ff} + 9'd1;
   assign done           = position_next >= {1'b0, size};

   always_comb begin
      position_in  = position_ff;
      lag_count_in = lag_count_ff;
      if (enable) begin
         position_in  = done ? '0 : position_next[fls_pkg::SAMPLES_WIDTH-1:0];
         lag_count_in = done ? '0 : lag_count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         lag_count_ff <= '0;
      end else begin
         position_ff  <= position_in;
         lag_count_ff <= lag_count_in;
      end
   end

   always_comb begin
      win.done = done;
      win.lags = done ? lag_count_next : '0;
      win.size = size;
   end

endmodule

// ===== rtl/core/fls_sleep_ctrl.sv =====
module fls_sleep_ctrl #(
   parameter int unsigned DELAY_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  fls_pkg::win_type                     win,
   input  logic [fls_pkg::PERCENT_WIDTH-1:0]    max_lag_percent,
   input  logic [fls_pkg::SLEEP_WIDTH-1:0]      max_sleep_time,
   input  logic [fls_pkg::DEFAULT_WIDTH-1:0]    default_increase_delay,
   output logic [fls_pkg::SLEEP_WIDTH-1:0]      sleep_time
);

   localparam int unsigned CW = (DELAY_WIDTH > fls_pkg::DEFAULT_WIDTH) ?
                                DELAY_WIDTH : fls_pkg::DEFAULT_WIDTH;

   logic                                 started_ff, started_in;
   logic [fls_pkg::SLEEP_WIDTH-1:0]      sleep_ff, sleep_in;
   logic [fls_pkg::STABLE_WIDTH-1:0]     stable_ff, stable_in;
   logic [DELAY_WIDTH-1:0]               delay_ff, delay_in;
   fls_pkg::change_type                  change_ff, change_in;

   logic [fls_pkg::SLEEP_WIDTH-1:0]      sleep_cur;
   logic [DELAY_WIDTH-1:0]               delay_cur;
   fls_pkg::change_type                  change_cur;
   logic [CW-1:0]                        default_ext;
   logic [CW-1:0]                        delay_max_ext;
   logic [CW-1:0]                        delay_cur_ext;
   logic [DELAY_WIDTH-1:0]               default_sat;
   logic [DELAY_WIDTH+1:0]               delay_trip;
   logic [DELAY_WIDTH-1:0]               delay_trip_sat;
   logic [fls_pkg::PROD_WIDTH-1:0]       lag_prod;
   logic [fls_pkg::PROD_WIDTH-1:0]       lag_limit;
   logic [fls_pkg::STABLE_WIDTH-1:0]     stable_inc;
   logic                                 stable;
   logic                                 recent_up;

   assign default_ext   = CW'(default_increase_delay);
   assign delay_max_ext = CW'({DELAY_WIDTH{1'b1}});
   assign default_sat   = (default_ext > delay_max_ext) ? {DELAY_WIDTH{1'b1}} :
                          default_ext[DELAY_WIDTH-1:0];

   // first beat loads half the maximum and the default delay
   assign sleep_cur  = started_ff ? sleep_ff : (max_sleep_time >> 1);
   assign delay_cur  = started_ff ? delay_ff : default_sat;
   assign change_cur = started_ff ? change_ff : fls_pkg::CHANGE_NONE;

   assign delay_cur_ext  = CW'(delay_cur);
   assign delay_trip     = {2'b00, delay_cur} + {1'b0, delay_cur, 1'b0};
   assign delay_trip_sat = (delay_trip[DELAY_WIDTH+1:DELAY_WIDTH] != 2'b00) ?
                           {DELAY_WIDTH{1'b1}} : delay_trip[DELAY_WIDTH-1:0];

   assign lag_prod  = fls_pkg::PROD_WIDTH'(win.lags) * fls_pkg::PERCENT_SCALE;
   assign lag_limit = fls_pkg::PROD_WIDTH'(max_lag_percent) *
                      fls_pkg::PROD_WIDTH'(win.size);
   assign stable    = lag_prod <= lag_limit;
   assign recent_up = (stable_ff <= fls_pkg::RECENT_LIMIT) &&
                      (change_cur == fls_pkg::CHANGE_UP);
   assign stable_inc = (stable_ff == fls_pkg::STABLE_MAX) ? stable_ff :
                       stable_ff + 16'd1;

   always_comb begin
      sleep_in  = sleep_cur;
      stable_in = stable_ff;
      delay_in  = delay_cur;
      change_in = change_cur;
      if (win.done) begin
         if (stable) begin
            if (CW'(stable_ff) < delay_cur_ext) begin
               stable_in = stable_inc;
               if (stable_inc <= fls_pkg::RECENT_LIMIT &&
                   change_cur == fls_pkg::CHANGE_UP) begin
                  delay_in = default_sat;
               end
            end else if (sleep_cur < max_sleep_time) begin
               stable_in = '0;
               sleep_in  = sleep_cur + 10'd1;
               change_in = fls_pkg::CHANGE_UP;
            end
         end else begin
            if (sleep_cur != '0) begin
               delay_in  = recent_up ? delay_trip_sat : default_sat;
               sleep_in  = sleep_cur - 10'd1;
               change_in = fls_pkg::CHANGE_DOWN;
            end
            stable_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         sleep_ff   <= '0;
         stable_ff  <= '0;
         delay_ff   <= '0;
         change_ff  <= fls_pkg::CHANGE_NONE;
      end else if (enable) begin
         started_ff <= started_in;
         sleep_ff   <= sleep_in;
         stable_ff  <= stable_in;
         delay_ff   <= delay_in;
         change_ff  <= change_in;
      end
   end

   assign started_in = 1'b1;
   assign sleep_time = sleep_in;

endmodule

// ===== rtl/core/frame_lag_sleep_controller_unit.sv =====
// Frame lag sleep controller.
// req_ channel: one beat per measured frame time (req_frame_time_us).
// rsp_ channel: one beat per request, in order, carrying the sleep time after
// that frame, whether the frame closed a window, and the window's lag count.
// csr_ port: write-only; csr_wen with csr_index 0..4 selects samples per
// window, frame period, max lag percent, max sleep time, default delay.
// Write it only while no beat is in flight.
// A request is held in the input register and evaluated on its way into the
// result register. Throughput: one beat per cycle while rsp_stall is low, set
// by the combinational window and sleep update between those two registers.
// When rsp_stall is high with a result waiting, one more request is still
// taken into the input register; req_stall then rises until the result moves.
// Reset (synchronous) empties both registers, clears the window and sleep
// state and restores the register defaults; the first frame afterwards loads
// half the maximum sleep time and the default delay.
module frame_lag_sleep_controller_unit #(
   parameter int unsigned DELAY_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fls_pkg::FRAME_WIDTH-1:0]      req_frame_time_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fls_pkg::SLEEP_WIDTH-1:0]      rsp_sleep_time,
   output logic                                 rsp_window_done,
   output logic [fls_pkg::SAMPLES_WIDTH-1:0]    rsp_window_lags,
   input  logic                                 csr_wen,
   input  logic [fls_pkg::INDEX_WIDTH-1:0]      csr_index,
   input  logic [fls_pkg::CSR_WIDTH-1:0]        csr_wdata
);

   logic [fls_pkg::SAMPLES_WIDTH-1:0] samples_ff;
   logic [fls_pkg::FRAME_WIDTH-1:0]   period_ff;
   logic [fls_pkg::PERCENT_WIDTH-1:0] percent_ff;
   logic [fls_pkg::SLEEP_WIDTH-1:0]   max_sleep_ff;
   logic [fls_pkg::DEFAULT_WIDTH-1:0] default_delay_ff;

   logic                              in_valid_ff, in_valid_in;
   logic [fls_pkg::FRAME_WIDTH-1:0]   frame_ff;
   logic                              out_valid_ff, out_valid_in;
   logic [fls_pkg::SLEEP_WIDTH-1:0]   out_sleep_ff;
   logic                              out_done_ff;
   logic [fls_pkg::SAMPLES_WIDTH-1:0] out_lags_ff;

   logic                              advance;
   logic                              accept;
   fls_pkg::win_type                  win;
   logic [fls_pkg::SLEEP_WIDTH-1:0]   sleep_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff       <= fls_pkg::RST_SAMPLES_PER_WINDOW;
         period_ff        <= fls_pkg::RST_FRAME_PERIOD_US;
         percent_ff       <= fls_pkg::RST_MAX_LAG_PERCENT;
         max_sleep_ff     <= fls_pkg::RST_MAX_SLEEP_TIME;
         default_delay_ff <= fls_pkg::RST_DEFAULT_DELAY;
      end else if (csr_wen) begin
         unique case (csr_index)
            fls_pkg::CSR_SAMPLES_PER_WINDOW: begin
               samples_ff <= csr_wdata[fls_pkg::SAMPLES_WIDTH-1:0];
            end
            fls_pkg::CSR_FRAME_PERIOD_US: begin
               period_ff <= csr_wdata[fls_pkg::FRAME_WIDTH-1:0];
            end
            fls_pkg::CSR_MAX_LAG_PERCENT: begin
               percent_ff <= csr_wdata[fls_pkg::PERCENT_WIDTH-1:0];
            end
            fls_pkg::CSR_MAX_SLEEP_TIME: begin
               max_sleep_ff <= csr_wdata[fls_pkg::SLEEP_WIDTH-1:0];
            end
            fls_pkg::CSR_DEFAULT_DELAY: begin
               default_delay_ff <= csr_wdata[fls_pkg::DEFAULT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff <= req_frame_time_us;
      end
      if (advance) begin
         out_sleep_ff <= sleep_next;
         out_done_ff  <= win.done;
         out_lags_ff  <= win.lags;
      end
   end

   fls_window u_window (
      .clock              (clock),
      .reset              (reset),
      .enable             (advance),
      .frame_time_us      (frame_ff),
      .samples_per_window (samples_ff),
      .frame_period_us    (period_ff),
      .win                (win)
   );

   fls_sleep_ctrl #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_sleep_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .enable                 (advance),
      .win                    (win),
      .max_lag_percent        (percent_ff),
      .max_sleep_time         (max_sleep_ff),
      .default_increase_delay (default_delay_ff),
      .sleep_time             (sleep_next)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_sleep_time  = out_sleep_ff;
   assign rsp_window_done = out_done_ff;
   assign rsp_window_lags = out_lags_ff;

   a_lags_only_on_close: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_done_ff) |-> (out_lags_ff == '0))
      else $error("lag count on a beat that closed no window");

   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff) |-> (!req_stall))
      else $error("request stalled with the result register empty");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated beat lost on its way to the result register");

endmodule
